>>> sv/linear_least_squares_fit_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef LINEAR_LEAST_SQUARES_FIT_MACROS_SVH
`define LINEAR_LEAST_SQUARES_FIT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define LLSF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define LLSF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/llsf_pkg.sv
`default_nettype none

package llsf_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QAW = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    FIT_OK         = 2'd0,
    FIT_DEN_ZERO   = 2'd1,
    FIT_FEW_POINTS = 2'd2,
    FIT_ST_ZERO    = 2'd3
  } fit_status_e;

  typedef struct packed {
    logic signed [15:0] sample_x;
    logic signed [15:0] sample_y;
    logic               final_pair;
  } llsf_in_t;

  typedef struct packed {
    logic signed [31:0] intercept;
    logic signed [31:0] slope;
    logic [47:0]        residual_sum_sq;
    logic [47:0]        total_sum_sq;
    logic [31:0]        std_error;
    logic [16:0]        correlation;
    fit_status_e        fit_status;
    logic               capacity_exceeded;
  } llsf_out_t;

  // One classified sample on its way from the front end to the engine.
  typedef struct packed {
    logic signed [15:0] sample_x;
    logic signed [15:0] sample_y;
    logic               final_pair;
    logic               store;
  } llsf_queue_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_M1,
    ST_M2,
    ST_M3,
    ST_M4,
    ST_M5,
    ST_CHK,
    ST_DIV_SLOPE,
    ST_M6,
    ST_ICPT,
    ST_DIV_ICPT,
    ST_DIV_MEAN,
    ST_P_RD,
    ST_P_MUL,
    ST_P_RES,
    ST_P_SQE,
    ST_P_SQD,
    ST_P_ACC,
    ST_FIN,
    ST_DIV_SE,
    ST_SQRT_SE,
    ST_DIV_CORR,
    ST_SQRT_CORR,
    ST_OUT
  } llsf_state_e;

endpackage

`default_nettype wire

>>> sv/llsf_front.sv
`default_nettype none

module llsf_front #(
  parameter int unsigned MAX_POINTS = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire llsf_pkg::llsf_in_t   in_data_i,
  output logic                      q_valid_o,
  input  wire logic                 q_ready_i,
  output llsf_pkg::llsf_queue_t     q_data_o
);
  import llsf_pkg::*;

  localparam int unsigned CW = $clog2(MAX_POINTS + 1);

  llsf_queue_t     q_mem [QUEUE_DEPTH];
  logic [QAW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QAW:0]    fill_q, fill_d;
  logic [CW-1:0]   seen_q, seen_d;
  logic            push, pop, store;
  llsf_queue_t     entry;

  assign in_stall_o = (fill_q == (QAW+1)'(QUEUE_DEPTH));
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (fill_q != '0);
  assign pop        = q_valid_o && q_ready_i;
  assign q_data_o   = q_mem[rd_ptr_q];

  // A pair is kept only while the data set still has room for it.
  assign store = (seen_q < CW'(MAX_POINTS));

  always_comb begin
    entry.sample_x   = in_data_i.sample_x;
    entry.sample_y   = in_data_i.sample_y;
    entry.final_pair = in_data_i.final_pair;
    entry.store      = store;
    wr_ptr_d = push ? wr_ptr_q + QAW'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + QAW'(1) : rd_ptr_q;
    fill_d   = fill_q + (QAW+1)'(push) - (QAW+1)'(pop);
    seen_d   = seen_q;
    if (push) begin
      if (in_data_i.final_pair) begin
        seen_d = '0;
      end else if (store) begin
        seen_d = seen_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
      seen_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
      seen_q   <= seen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= entry;
    end
  end

endmodule

`default_nettype wire

>>> sv/llsf_div.sv
`default_nettype none

module llsf_div #(
  parameter int unsigned NW = 80,
  parameter int unsigned DW = 48
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  output logic               done_o,
  output logic [NW-1:0]      quot_o
);
  import llsf_pkg::*;

  localparam int unsigned CNTW = $clog2(NW + 1);

  logic            busy_q, done_q;
  logic [CNTW-1:0] cnt_q;
  logic [NW-1:0]   a_q;
  logic [DW-1:0]   r_q, den_q;
  logic [DW:0]     r_sh, r_nx;
  logic            ge;

  // Restoring division, one quotient bit per cycle; quotient bits shift
  // into the numerator register as its bits are consumed.
  assign r_sh   = {r_q, a_q[NW-1]};
  assign ge     = (r_sh >= {1'b0, den_q});
  assign r_nx   = ge ? r_sh - {1'b0, den_q} : r_sh;
  assign done_o = done_q;
  assign quot_o = a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CNTW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNTW'(NW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNTW'(1);
        if (cnt_q == CNTW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= num_i;
      r_q   <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      a_q <= {a_q[NW-2:0], ge};
      r_q <= r_nx[DW-1:0];
    end
  end

endmodule

`default_nettype wire

>>> sv/llsf_isqrt.sv
`default_nettype none

module llsf_isqrt (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] arg_i,
  output logic             done_o,
  output logic [31:0]      root_o
);
  import llsf_pkg::*;

  logic        busy_q, done_q;
  logic [5:0]  cnt_q;
  logic [63:0] v_q, res_q, bit_q, trial;
  logic        ge;

  // Digit-by-digit square root: one result bit per cycle.
  assign trial  = res_q + bit_q;
  assign ge     = (v_q >= trial);
  assign done_o = done_q;
  assign root_o = res_q[31:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == 6'd1);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd32;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q   <= arg_i;
      res_q <= '0;
      bit_q <= 64'h4000_0000_0000_0000;
    end else if (busy_q) begin
      v_q   <= ge ? v_q - trial : v_q;
      res_q <= ge ? (res_q >> 1) + bit_q : res_q >> 1;
      bit_q <= bit_q >> 2;
    end
  end

endmodule

`default_nettype wire

>>> sv/llsf_back.sv
`default_nettype none

module llsf_back #(
  parameter int unsigned MAX_POINTS = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  q_valid_i,
  output logic                       q_ready_o,
  input  wire llsf_pkg::llsf_queue_t q_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output llsf_pkg::llsf_out_t        out_data_o
);
  import llsf_pkg::*;

  localparam int unsigned CW  = $clog2(MAX_POINTS + 1);
  localparam int unsigned AW  = $clog2(MAX_POINTS);
  localparam int unsigned SXW = 16 + CW;
  localparam int unsigned SPW = 31 + CW;
  localparam int unsigned NMW = 32 + 2 * CW;
  localparam int unsigned TW  = (NMW > 48 + CW) ? NMW : 48 + CW;
  localparam int unsigned VW  = TW + 1;
  localparam int unsigned EW  = TW + 2;
  localparam int unsigned YW  = SXW + 8;
  localparam int unsigned NW  = (49 + 2 * CW > 80) ? 49 + 2 * CW : 80;
  localparam int unsigned DW  = (NMW > 48) ? NMW : 48;
  localparam logic [NW-1:0] POS_LIM = NW'(32'h7FFF_FFFF);
  localparam logic [NW-1:0] NEG_LIM = NW'(32'h8000_0000);

  function automatic logic [31:0] sat_mag(input logic [NW-1:0] m, input logic neg);
    logic [31:0] r;
    if (neg) begin
      r = (m > NEG_LIM) ? 32'h8000_0000 : 32'(-m[31:0]);
    end else begin
      r = (m > POS_LIM) ? 32'h7FFF_FFFF : m[31:0];
    end
    return r;
  endfunction

  function automatic logic [47:0] sat_add(input logic [47:0] a, input logic [47:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[48] ? 48'hFFFF_FFFF_FFFF : s[47:0];
  endfunction

  llsf_state_e state_q, state_d;

  logic [31:0]            mem [MAX_POINTS];
  logic [31:0]            rd_q;
  logic                   mem_we;

  logic signed [SXW-1:0]  sum_x_q, sum_x_d, sum_y_q, sum_y_d;
  logic signed [SPW-1:0]  sum_xy_q, sum_xy_d, sum_xx_q, sum_xx_d;
  logic [CW-1:0]          cnt_q, cnt_d, j_q, j_d;
  logic                   ovf_q, ovf_d;

  logic signed [TW-1:0]   ta_q, ta_d, tb_q, tb_d;
  logic signed [NMW-1:0]  num_q, num_d, den_q, den_d;
  logic signed [31:0]     slope_q, slope_d, icpt_q, icpt_d;
  logic signed [24:0]     ymean_q, ymean_d;
  logic signed [25:0]     dev_q, dev_d;
  logic [EW-9:0]          e_q, e_d;
  logic [47:0]            sqe_q, sqe_d, sqd_q, sqd_d;
  logic [47:0]            sr_q, sr_d, st_q, st_d;
  logic [31:0]            se_q, se_d;
  logic [16:0]            corr_q, corr_d;
  fit_status_e            status_q, status_d;

  logic                   out_valid_q, out_valid_d;
  llsf_out_t              out_data_q, out_data_d;

  logic                   div_start, div_done, sq_start, sq_done;
  logic [NW-1:0]          div_num, quot;
  logic [DW-1:0]          div_den;
  logic [63:0]            sq_arg;
  logic [31:0]            root;

  logic signed [CW:0]     n_s;
  logic signed [NMW-1:0]  p_nxy, p_sxsy, p_nxx, p_sxsx;
  logic signed [TW-1:0]   p_slsx, p_slx;
  logic signed [31:0]     p_xy, p_xx;
  logic [63:0]            sqe_prod, sqe_rnd;
  logic [49:0]            sqd_prod, sqd_rnd;
  logic [NMW-1:0]         num_mag, den_mag;
  logic signed [VW-1:0]   iv;
  logic [VW-1:0]          iv_mag;
  logic signed [YW-1:0]   mv;
  logic [YW-1:0]          mv_mag;
  logic signed [EW-1:0]   ev;
  logic [EW-1:0]          ev_mag, em;
  logic [24:0]            dv_mag;
  logic [NW:0]            q_plus;
  logic [47:0]            diff;
  logic signed [15:0]     rd_x, rd_y;

  assign rd_x = rd_q[31:16];
  assign rd_y = rd_q[15:0];
  assign n_s  = $signed({1'b0, cnt_q});

  assign p_nxy    = n_s * sum_xy_q;
  assign p_sxsy   = sum_x_q * sum_y_q;
  assign p_nxx    = n_s * sum_xx_q;
  assign p_sxsx   = sum_x_q * sum_x_q;
  assign p_slsx   = slope_q * sum_x_q;
  assign p_slx    = slope_q * rd_x;
  assign p_xy     = q_data_i.sample_x * q_data_i.sample_y;
  assign p_xx     = q_data_i.sample_x * q_data_i.sample_x;
  assign sqe_prod = e_q[31:0] * e_q[31:0];
  assign sqe_rnd  = sqe_prod + 64'd32768;
  assign sqd_prod = dv_mag * dv_mag;
  assign sqd_rnd  = sqd_prod + 50'd32768;

  assign num_mag = num_q[NMW-1] ? $unsigned(-num_q) : $unsigned(num_q);
  assign den_mag = den_q[NMW-1] ? $unsigned(-den_q) : $unsigned(den_q);
  assign iv      = (VW'(sum_y_q) <<< 16) - VW'(ta_q);
  assign iv_mag  = iv[VW-1] ? $unsigned(-iv) : $unsigned(iv);
  assign mv      = YW'(sum_y_q) <<< 8;
  assign mv_mag  = mv[YW-1] ? $unsigned(-mv) : $unsigned(mv);
  assign ev      = (EW'(rd_y) <<< 16) - (EW'(icpt_q) <<< 8) - EW'(ta_q);
  assign ev_mag  = ev[EW-1] ? $unsigned(-ev) : $unsigned(ev);
  assign em      = ev_mag + EW'(128);
  assign dv_mag  = dev_q[25] ? 25'($unsigned(-dev_q)) : 25'($unsigned(dev_q));
  assign q_plus  = {1'b0, quot} + (NW+1)'(1);
  assign diff    = (sr_q > st_q) ? 48'd0 : st_q - sr_q;

  assign q_ready_o   = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  llsf_div #(
    .NW (NW),
    .DW (DW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  llsf_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .arg_i   (sq_arg),
    .done_o  (sq_done),
    .root_o  (root)
  );

  always_comb begin
    state_d     = state_q;
    sum_x_d     = sum_x_q;
    sum_y_d     = sum_y_q;
    sum_xy_d    = sum_xy_q;
    sum_xx_d    = sum_xx_q;
    cnt_d       = cnt_q;
    j_d         = j_q;
    ovf_d       = ovf_q;
    ta_d        = ta_q;
    tb_d        = tb_q;
    num_d       = num_q;
    den_d       = den_q;
    slope_d     = slope_q;
    icpt_d      = icpt_q;
    ymean_d     = ymean_q;
    dev_d       = dev_q;
    e_d         = e_q;
    sqe_d       = sqe_q;
    sqd_d       = sqd_q;
    sr_d        = sr_q;
    st_d        = st_q;
    se_d        = se_q;
    corr_d      = corr_q;
    status_d    = status_q;
    mem_we      = 1'b0;
    div_start   = 1'b0;
    div_num     = '0;
    div_den     = '0;
    sq_start    = 1'b0;
    sq_arg      = quot[63:0];
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;

    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          if (q_data_i.store) begin
            mem_we   = 1'b1;
            sum_x_d  = sum_x_q + SXW'(q_data_i.sample_x);
            sum_y_d  = sum_y_q + SXW'(q_data_i.sample_y);
            sum_xy_d = sum_xy_q + SPW'(p_xy);
            sum_xx_d = sum_xx_q + SPW'(p_xx);
            cnt_d    = cnt_q + CW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (q_data_i.final_pair) begin
            state_d = ST_M1;
          end
        end
      end
      ST_M1: begin
        ta_d    = TW'(p_nxy);
        state_d = ST_M2;
      end
      ST_M2: begin
        tb_d    = TW'(p_sxsy);
        state_d = ST_M3;
      end
      ST_M3: begin
        num_d   = NMW'(ta_q - tb_q);
        ta_d    = TW'(p_nxx);
        state_d = ST_M4;
      end
      ST_M4: begin
        tb_d    = TW'(p_sxsx);
        state_d = ST_M5;
      end
      ST_M5: begin
        den_d   = NMW'(ta_q - tb_q);
        state_d = ST_CHK;
      end
      ST_CHK: begin
        if (den_q == '0 || cnt_q == '0) begin
          // Degenerate fit: every numeric field reads as zero.
          status_d = FIT_DEN_ZERO;
          slope_d  = '0;
          icpt_d   = '0;
          sr_d     = '0;
          st_d     = '0;
          se_d     = '0;
          corr_d   = '0;
          state_d  = ST_OUT;
        end else begin
          div_start = 1'b1;
          div_num   = NW'({num_mag, 17'b0});
          div_den   = DW'(den_mag);
          state_d   = ST_DIV_SLOPE;
        end
      end
      ST_DIV_SLOPE: begin
        if (div_done) begin
          // One extra fraction bit was computed so the slope rounds to nearest.
          slope_d = $signed(sat_mag(q_plus[NW:1], num_q[NMW-1] ^ den_q[NMW-1]));
          state_d = ST_M6;
        end
      end
      ST_M6: begin
        ta_d    = p_slsx;
        state_d = ST_ICPT;
      end
      ST_ICPT: begin
        div_start = 1'b1;
        div_num   = NW'(iv_mag) + NW'({cnt_q, 7'b0});
        div_den   = DW'({cnt_q, 8'b0});
        state_d   = ST_DIV_ICPT;
      end
      ST_DIV_ICPT: begin
        if (div_done) begin
          icpt_d    = $signed(sat_mag(quot, iv[VW-1]));
          div_start = 1'b1;
          div_num   = NW'(mv_mag) + NW'(cnt_q >> 1);
          div_den   = DW'(cnt_q);
          state_d   = ST_DIV_MEAN;
        end
      end
      ST_DIV_MEAN: begin
        if (div_done) begin
          ymean_d = mv[YW-1] ? -$signed(quot[24:0]) : $signed(quot[24:0]);
          j_d     = '0;
          sr_d    = '0;
          st_d    = '0;
          state_d = ST_P_RD;
        end
      end
      ST_P_RD: begin
        state_d = ST_P_MUL;
      end
      ST_P_MUL: begin
        ta_d    = p_slx;
        dev_d   = (26'(rd_y) <<< 8) - 26'(ymean_q);
        state_d = ST_P_RES;
      end
      ST_P_RES: begin
        e_d     = em[EW-1:8];
        state_d = ST_P_SQE;
      end
      ST_P_SQE: begin
        sqe_d   = (|e_q[EW-9:32]) ? 48'hFFFF_FFFF_FFFF : sqe_rnd[63:16];
        state_d = ST_P_SQD;
      end
      ST_P_SQD: begin
        sqd_d   = 48'(sqd_rnd[49:16]);
        state_d = ST_P_ACC;
      end
      ST_P_ACC: begin
        sr_d = sat_add(sr_q, sqe_q);
        st_d = sat_add(st_q, sqd_q);
        j_d  = j_q + CW'(1);
        if (j_d == cnt_q) begin
          state_d = ST_FIN;
        end else begin
          state_d = ST_P_RD;
        end
      end
      ST_FIN: begin
        if (cnt_q < CW'(3)) begin
          status_d = FIT_FEW_POINTS;
          se_d     = '0;
          corr_d   = '0;
          state_d  = ST_OUT;
        end else begin
          div_start = 1'b1;
          div_num   = NW'({sr_q, 16'b0});
          div_den   = DW'(cnt_q - CW'(2));
          state_d   = ST_DIV_SE;
        end
      end
      ST_DIV_SE: begin
        if (div_done) begin
          sq_start = 1'b1;
          state_d  = ST_SQRT_SE;
        end
      end
      ST_SQRT_SE: begin
        if (sq_done) begin
          se_d = root;
          if (st_q == '0) begin
            status_d = FIT_ST_ZERO;
            corr_d   = '0;
            state_d  = ST_OUT;
          end else begin
            div_start = 1'b1;
            div_num   = NW'({diff, 32'b0});
            div_den   = DW'(st_q);
            state_d   = ST_DIV_CORR;
          end
        end
      end
      ST_DIV_CORR: begin
        if (div_done) begin
          sq_start = 1'b1;
          state_d  = ST_SQRT_CORR;
        end
      end
      ST_SQRT_CORR: begin
        if (sq_done) begin
          corr_d   = root[16:0];
          status_d = FIT_OK;
          state_d  = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d                  = 1'b1;
          out_data_d.intercept         = icpt_q;
          out_data_d.slope             = slope_q;
          out_data_d.residual_sum_sq   = sr_q;
          out_data_d.total_sum_sq      = st_q;
          out_data_d.std_error         = se_q;
          out_data_d.correlation       = corr_q;
          out_data_d.fit_status        = status_q;
          out_data_d.capacity_exceeded = ovf_q;
          sum_x_d  = '0;
          sum_y_d  = '0;
          sum_xy_d = '0;
          sum_xx_d = '0;
          cnt_d    = '0;
          ovf_d    = 1'b0;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sum_x_q     <= '0;
      sum_y_q     <= '0;
      sum_xy_q    <= '0;
      sum_xx_q    <= '0;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_x_q     <= sum_x_d;
      sum_y_q     <= sum_y_d;
      sum_xy_q    <= sum_xy_d;
      sum_xx_q    <= sum_xx_d;
      cnt_q       <= cnt_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    j_q        <= j_d;
    ta_q       <= ta_d;
    tb_q       <= tb_d;
    num_q      <= num_d;
    den_q      <= den_d;
    slope_q    <= slope_d;
    icpt_q     <= icpt_d;
    ymean_q    <= ymean_d;
    dev_q      <= dev_d;
    e_q        <= e_d;
    sqe_q      <= sqe_d;
    sqd_q      <= sqd_d;
    sr_q       <= sr_d;
    st_q       <= st_d;
    se_q       <= se_d;
    corr_q     <= corr_d;
    status_q   <= status_d;
    out_data_q <= out_data_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[cnt_q[AW-1:0]] <= {q_data_i.sample_x, q_data_i.sample_y};
    end
    rd_q <= mem[j_q[AW-1:0]];
  end

endmodule

`default_nettype wire

>>> sv/linear_least_squares_fit.sv
`default_nettype none

// Least-squares line fit over data sets of Q8.8 (x, y) pairs. Pairs enter
// through a four-entry queue and the idle engine folds one pair per cycle
// into its sums and sample memory, so a data set streams in at one pair per
// cycle while no fit is running. The pair marked final_pair starts the fit,
// which holds the engine for up to five passes of the shared 80-step divider,
// up to two passes of the 32-step square root and a second pass over the
// sample memory. Meanwhile the queue keeps taking pairs of the next data set
// until it fills. Pairs beyond MAX_POINTS are dropped and reported through
// capacity_exceeded.

module linear_least_squares_fit #(
  parameter int unsigned MAX_POINTS = 32
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire llsf_pkg::llsf_in_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output llsf_pkg::llsf_out_t      out_data_o
);
  import llsf_pkg::*;

  llsf_queue_t q_data;
  logic        q_valid, q_ready;

  llsf_front #(
    .MAX_POINTS (MAX_POINTS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_valid_o  (q_valid),
    .q_ready_i  (q_ready),
    .q_data_o   (q_data)
  );

  llsf_back #(
    .MAX_POINTS (MAX_POINTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_ready_o   (q_ready),
    .q_data_i    (q_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

>>> sv/llsf_checker.sv
`default_nettype none

`include "linear_least_squares_fit_macros.svh"

module llsf_props (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_stall_o,
  input wire llsf_pkg::llsf_in_t  in_data_i,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire llsf_pkg::llsf_out_t out_data_o
);
  import llsf_pkg::*;

  `LLSF_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o,
    "result dropped while stalled")
  `LLSF_ASSERT_NEXT(a_out_stable, out_valid_o && out_stall_i, $stable(out_data_o),
    "stalled result changed")
  `LLSF_ASSERT_NOW(a_den_zero, out_valid_o && out_data_o.fit_status == FIT_DEN_ZERO,
    out_data_o.slope == 0 && out_data_o.intercept == 0 &&
    out_data_o.residual_sum_sq == 0 && out_data_o.total_sum_sq == 0 &&
    out_data_o.std_error == 0 && out_data_o.correlation == 0,
    "degenerate fit with nonzero field")
  `LLSF_ASSERT_NOW(a_few_points, out_valid_o && out_data_o.fit_status == FIT_FEW_POINTS,
    out_data_o.std_error == 0 && out_data_o.correlation == 0,
    "short data set with error terms")
  `LLSF_ASSERT_NOW(a_corr_range, out_valid_o, out_data_o.correlation <= 17'd65536,
    "correlation above one")

endmodule

bind linear_least_squares_fit llsf_props u_props (.*);

`default_nettype wire
